[rtl/core/pushdown_automaton_recognizer_assert.svh]
// Assertion macros for the pushdown recognizer.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PUSHDOWN_AUTOMATON_RECOGNIZER_ASSERT_SVH
`define PUSHDOWN_AUTOMATON_RECOGNIZER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define PDA_ASSERT_SAME(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define PDA_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pda_pkg.sv]
package pda_pkg;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_SYMBOL = 2'd1;
    localparam logic [1:0] CMD_END    = 2'd2;

    localparam logic [0:0] CFG_START  = 1'd0;
    localparam logic [0:0] CFG_ACCEPT = 1'd1;

    localparam logic [2:0] VERDICT_PENDING  = 3'd0;
    localparam logic [2:0] VERDICT_ACCEPTED = 3'd1;
    localparam logic [2:0] VERDICT_REJECTED = 3'd2;
    localparam logic [2:0] VERDICT_OVERFLOW = 3'd3;
    localparam logic [2:0] VERDICT_STEPS    = 3'd4;

    // Byte seen by a pop of an empty stack or a read past the end of the string.
    localparam logic [7:0] END_BYTE = 8'h7a;

    typedef enum logic [1:0] {
        ACT_READ = 2'd0,
        ACT_PUSH = 2'd1,
        ACT_POP  = 2'd2
    } act_kind_t;

    typedef enum logic [1:0] {
        K_LOAD,
        K_SYMBOL,
        K_END,
        K_NOP
    } item_kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CHECK,
        B_ACT,
        B_POP,
        B_TRANS,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] state_index;
        logic [7:0] symbol;
        logic [3:0] next_state;
        logic [1:0] action_kind;
    } in_item_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic       string_done;
    } out_item_t;

    // Classified item as it waits between the front and the back.
    typedef struct packed {
        item_kind_t kind;
        logic [3:0] src;
        logic [7:0] sym;
        logic [3:0] dst;
        act_kind_t  act;
        logic       act_wr;
    } q_entry_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_status_t;

    // Reduces a 4-bit state number modulo the number of states.
    function automatic logic [3:0] state_mod(input logic [3:0] v, input int unsigned n);
        logic [3:0] r;
        r = v;
        for (int i = 0; i < 8; i++)
        begin
            if (32'(r) >= n)
            begin
                r = r - 4'(n);
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/pushdown_automaton_recognizer.sv]
// Programmable deterministic pushdown recognizer.
// Input channel (in_valid/in_stall/in_data): load, symbol and end transactions.
// A load writes one transition and, if known, its state's action. Symbols feed the
// read steps of the current string; an end transaction runs the machine to a
// verdict and closes the string. Every input transaction yields exactly one
// result on the output channel (out_valid/out_stall/out_data), in order.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets the start
// and accept states; it is always ready and is meant to be written while idle.
// A load, an unknown command, or a symbol or end that only repeats a verdict goes
// straight to the result state. Other symbols and ends step through the sequencer's
// check, action, pop and transition states, with registered reads of the action,
// stack and transition memories, until a verdict, the step or stack limit, or a
// read that waits for the next symbol.
// A two-entry queue lets the input side accept while the sequencer is busy.
// After reset the transition memory is swept clear, one entry per cycle; in_stall
// is high meanwhile.
// When the receiver stalls, the result register holds and the queue fills.
`include "pushdown_automaton_recognizer_assert.svh"

module pushdown_automaton_recognizer #(
    parameter int NUM_STATES  = 16,
    parameter int STACK_DEPTH = 64,
    parameter int STEP_LIMIT  = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pda_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output pda_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [3:0]         cfg_data
);

    import pda_pkg::*;

    logic [3:0]   start_state_reg;
    logic [3:0]   accept_state_reg;
    logic         q_valid;
    q_entry_t     q_entry;
    back_status_t status;
    logic         out_done;
    logic         out_pending;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg  <= 4'd0;
            accept_state_reg <= 4'd15;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_START:  start_state_reg  <= cfg_data;
                CFG_ACCEPT: accept_state_reg <= cfg_data;
            endcase
        end
    end

    pda_front #(.NUM_STATES(NUM_STATES)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .status   (status),
        .q_valid  (q_valid),
        .q_entry  (q_entry)
    );

    pda_back #(
        .NUM_STATES  (NUM_STATES),
        .STACK_DEPTH (STACK_DEPTH),
        .STEP_LIMIT  (STEP_LIMIT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .status       (status),
        .start_state  (start_state_reg),
        .accept_state (accept_state_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

    assign out_done    = out_valid && out_data.string_done;
    assign out_pending = (out_data.verdict == VERDICT_PENDING);

    `PDA_ASSERT_SAME(a_pop_needs_entry, status.pop, q_valid, "queue popped while empty")
    `PDA_ASSERT_SAME(a_clear_blocks_input, status.clearing, in_stall, "input open during clear")
    `PDA_ASSERT_NEXT(a_one_pop_per_item, status.pop, !status.pop, "back-to-back queue pops")
    `PDA_ASSERT_SAME(a_done_has_verdict, out_done, !out_pending, "string closed while pending")

endmodule

[rtl/core/pda_ram.sv]
module pda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/pda_front.sv]
module pda_front #(
    parameter int NUM_STATES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pda_pkg::in_item_t     in_data,
    input  pda_pkg::back_status_t status,
    output logic                  q_valid,
    output pda_pkg::q_entry_t     q_entry
);

    import pda_pkg::*;

    localparam int QD = 2;

    q_entry_t   ent_reg [QD];
    q_entry_t   classified;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    always_comb
    begin
        unique case (in_data.command)
            CMD_LOAD:   classified.kind = K_LOAD;
            CMD_SYMBOL: classified.kind = K_SYMBOL;
            CMD_END:    classified.kind = K_END;
            default:    classified.kind = K_NOP;
        endcase
        classified.src    = state_mod(in_data.state_index, NUM_STATES);
        classified.sym    = in_data.symbol;
        classified.dst    = state_mod(in_data.next_state, NUM_STATES);
        classified.act    = act_kind_t'(in_data.action_kind);
        // An unknown action code still writes the transition but keeps the action.
        classified.act_wr = (in_data.action_kind == ACT_READ) ||
                            (in_data.action_kind == ACT_PUSH) ||
                            (in_data.action_kind == ACT_POP);
    end

    assign in_stall = (count_reg == 2'(QD)) || status.clearing;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_entry  = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = status.pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(status.pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/pda_back.sv]
module pda_back #(
    parameter int NUM_STATES  = 16,
    parameter int STACK_DEPTH = 64,
    parameter int STEP_LIMIT  = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  pda_pkg::q_entry_t     q_entry,
    output pda_pkg::back_status_t status,
    input  logic [3:0]            start_state,
    input  logic [3:0]            accept_state,
    output logic                  out_valid,
    input  logic                  out_stall,
    output pda_pkg::out_item_t    out_data
);

    import pda_pkg::*;

    localparam int SW     = $clog2(NUM_STATES);
    localparam int CW     = (SW > 4) ? SW : 4;
    localparam int TW     = SW + 8;
    localparam int TDEPTH = NUM_STATES * 256;
    localparam int AW     = $clog2(STACK_DEPTH);
    localparam int PW     = $clog2(STACK_DEPTH + 1);
    localparam int NW     = $clog2(STEP_LIMIT + 1);
    localparam logic [TW-1:0] CLR_LAST = TW'(TDEPTH - 1);

    back_state_t           state_reg, state_next;
    logic [SW-1:0]         ps_reg, ps_next;
    logic [PW-1:0]         sp_reg, sp_next;
    logic [NW-1:0]         step_reg, step_next;
    logic [2:0]            verdict_reg, verdict_next;
    logic                  in_string_reg, in_string_next;
    logic                  ending_reg, ending_next;
    logic                  have_reg, have_next;
    logic [7:0]            sym_reg, sym_next;
    logic                  clearing_reg, clearing_next;
    logic [TW-1:0]         clr_addr_reg, clr_addr_next;
    logic [NUM_STATES-1:0] act_valid_reg, act_valid_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_data_reg, out_data_next;

    logic          tr_we, tr_re;
    logic [TW-1:0] tr_waddr, tr_raddr;
    logic [SW:0]   tr_wdata, tr_rdata;
    logic          act_we, act_re;
    logic [SW-1:0] act_waddr, act_raddr;
    logic [9:0]    act_wdata, act_rdata;
    logic          st_we, st_re;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [7:0]    st_wdata, st_rdata;

    logic [SW-1:0] start_idx;
    act_kind_t     cur_kind;
    logic [7:0]    cur_byte;
    logic          at_accept, next_accept, tr_hit;
    logic [SW-1:0] tr_next;
    logic          wait_sym, step_out, stack_full, stack_empty;
    logic [PW-1:0] sp_dec;
    logic          out_free, take;

    // Transition table: valid bit over the next state, keyed by {state, byte}.
    pda_ram #(.WIDTH(SW + 1), .DEPTH(TDEPTH)) u_trans_ram (
        .clk     (clk),
        .wr_en   (tr_we),
        .wr_addr (tr_waddr),
        .wr_data (tr_wdata),
        .rd_en   (tr_re),
        .rd_addr (tr_raddr),
        .rd_data (tr_rdata)
    );

    // Action per state: kind over the push byte.
    pda_ram #(.WIDTH(10), .DEPTH(NUM_STATES)) u_act_ram (
        .clk     (clk),
        .wr_en   (act_we),
        .wr_addr (act_waddr),
        .wr_data (act_wdata),
        .rd_en   (act_re),
        .rd_addr (act_raddr),
        .rd_data (act_rdata)
    );

    pda_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_en   (st_re),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    assign start_idx   = SW'(state_mod(start_state, NUM_STATES));
    // A state whose action was never loaded reads, with a zero byte.
    assign cur_kind    = act_valid_reg[ps_reg] ? act_kind_t'(act_rdata[9:8]) : ACT_READ;
    assign cur_byte    = act_valid_reg[ps_reg] ? act_rdata[7:0] : 8'h00;
    assign at_accept   = (CW'(ps_reg) == CW'(accept_state));
    assign tr_hit      = tr_rdata[SW];
    assign tr_next     = tr_rdata[SW-1:0];
    assign next_accept = (CW'(tr_next) == CW'(accept_state));
    assign wait_sym    = (cur_kind == ACT_READ) && !ending_reg && !have_reg;
    assign step_out    = (step_reg >= NW'(STEP_LIMIT));
    assign stack_full  = (sp_reg >= PW'(STACK_DEPTH));
    assign stack_empty = (sp_reg == '0);
    assign sp_dec      = sp_reg - PW'(1);
    assign out_free    = !out_valid_reg || !out_stall;
    assign take        = (state_reg == B_IDLE) && q_valid && !clearing_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (take)
                begin
                    unique case (q_entry.kind)
                        K_SYMBOL, K_END:
                        begin
                            if (in_string_reg && (verdict_reg != VERDICT_PENDING))
                            begin
                                state_next = B_EMIT;
                            end
                            else
                            begin
                                state_next = B_CHECK;
                            end
                        end
                        default: state_next = B_EMIT;
                    endcase
                end
            end
            B_CHECK:
            begin
                state_next = at_accept ? B_EMIT : B_ACT;
            end
            B_ACT:
            begin
                priority if (wait_sym || step_out)
                begin
                    state_next = B_EMIT;
                end
                else
                begin
                    unique case (cur_kind)
                        ACT_PUSH: state_next = stack_full ? B_EMIT : B_TRANS;
                        ACT_POP:  state_next = stack_empty ? B_TRANS : B_POP;
                        default:  state_next = B_TRANS;
                    endcase
                end
            end
            B_POP:
            begin
                state_next = B_TRANS;
            end
            B_TRANS:
            begin
                state_next = (!tr_hit || next_accept) ? B_EMIT : B_ACT;
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        ps_next        = ps_reg;
        sp_next        = sp_reg;
        step_next      = step_reg;
        verdict_next   = verdict_reg;
        in_string_next = in_string_reg;
        ending_next    = ending_reg;
        have_next      = have_reg;
        sym_next       = sym_reg;
        clearing_next  = clearing_reg;
        clr_addr_next  = clr_addr_reg;
        act_valid_next = act_valid_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        status.pop      = 1'b0;
        status.clearing = clearing_reg;

        tr_we     = 1'b0;
        tr_waddr  = '0;
        tr_wdata  = '0;
        tr_re     = 1'b0;
        tr_raddr  = '0;
        act_we    = 1'b0;
        act_waddr = '0;
        act_wdata = '0;
        act_re    = 1'b0;
        act_raddr = '0;
        st_we     = 1'b0;
        st_waddr  = '0;
        st_wdata  = '0;
        st_re     = 1'b0;
        st_raddr  = '0;

        // After reset every transition entry is marked invalid, one per cycle.
        if (clearing_reg)
        begin
            tr_we         = 1'b1;
            tr_waddr      = clr_addr_reg;
            clr_addr_next = clr_addr_reg + TW'(1);
            if (clr_addr_reg == CLR_LAST)
            begin
                clearing_next = 1'b0;
            end
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (take)
                begin
                    status.pop  = 1'b1;
                    ending_next = 1'b0;
                    sym_next    = q_entry.sym;
                    unique case (q_entry.kind)
                        K_LOAD:
                        begin
                            tr_we    = 1'b1;
                            tr_waddr = {SW'(q_entry.src), q_entry.sym};
                            tr_wdata = {1'b1, SW'(q_entry.dst)};
                            if (q_entry.act_wr)
                            begin
                                act_we    = 1'b1;
                                act_waddr = SW'(q_entry.src);
                                act_wdata = {q_entry.act, q_entry.sym};
                                act_valid_next[SW'(q_entry.src)] = 1'b1;
                            end
                        end
                        K_SYMBOL, K_END:
                        begin
                            have_next   = (q_entry.kind == K_SYMBOL);
                            ending_next = (q_entry.kind == K_END);
                            if (!in_string_reg)
                            begin
                                in_string_next = 1'b1;
                                ps_next        = start_idx;
                                sp_next        = '0;
                                step_next      = '0;
                                verdict_next   = VERDICT_PENDING;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_CHECK:
            begin
                if (at_accept)
                begin
                    verdict_next = VERDICT_ACCEPTED;
                end
                else
                begin
                    act_re    = 1'b1;
                    act_raddr = ps_reg;
                end
            end
            B_ACT:
            begin
                priority if (wait_sym)
                begin
                end
                else if (step_out)
                begin
                    verdict_next = VERDICT_STEPS;
                end
                else
                begin
                    step_next = step_reg + NW'(1);
                    unique case (cur_kind)
                        ACT_PUSH:
                        begin
                            if (stack_full)
                            begin
                                verdict_next = VERDICT_OVERFLOW;
                            end
                            else
                            begin
                                st_we    = 1'b1;
                                st_waddr = sp_reg[AW-1:0];
                                st_wdata = cur_byte;
                                sp_next  = sp_reg + PW'(1);
                                tr_re    = 1'b1;
                                tr_raddr = {ps_reg, cur_byte};
                            end
                        end
                        ACT_POP:
                        begin
                            if (stack_empty)
                            begin
                                tr_re    = 1'b1;
                                tr_raddr = {ps_reg, END_BYTE};
                            end
                            else
                            begin
                                sp_next  = sp_dec;
                                st_re    = 1'b1;
                                st_raddr = sp_dec[AW-1:0];
                            end
                        end
                        default:
                        begin
                            have_next = 1'b0;
                            tr_re     = 1'b1;
                            tr_raddr  = {ps_reg, ending_reg ? END_BYTE : sym_reg};
                        end
                    endcase
                end
            end
            B_POP:
            begin
                tr_re    = 1'b1;
                tr_raddr = {ps_reg, st_rdata};
            end
            B_TRANS:
            begin
                if (!tr_hit)
                begin
                    verdict_next = VERDICT_REJECTED;
                end
                else
                begin
                    ps_next = tr_next;
                    if (next_accept)
                    begin
                        verdict_next = VERDICT_ACCEPTED;
                    end
                    else
                    begin
                        act_re    = 1'b1;
                        act_raddr = tr_next;
                    end
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.verdict     = verdict_reg;
                    out_data_next.string_done = ending_reg;
                    if (ending_reg)
                    begin
                        in_string_next = 1'b0;
                        sp_next        = '0;
                        step_next      = '0;
                        verdict_next   = VERDICT_PENDING;
                        ps_next        = start_idx;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sym_reg      <= sym_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            ps_reg        <= '0;
            sp_reg        <= '0;
            step_reg      <= '0;
            verdict_reg   <= VERDICT_PENDING;
            in_string_reg <= 1'b0;
            ending_reg    <= 1'b0;
            have_reg      <= 1'b0;
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            act_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ps_reg        <= ps_next;
            sp_reg        <= sp_next;
            step_reg      <= step_next;
            verdict_reg   <= verdict_next;
            in_string_reg <= in_string_next;
            ending_reg    <= ending_next;
            have_reg      <= have_next;
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            act_valid_reg <= act_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
    import pda_pkg::*;

    localparam int NUM_STATES  = 16;
    localparam int STACK_DEPTH = 64;
    localparam int STEP_LIMIT  = 256;

    // One item can run up to STEP_LIMIT steps, behind a stalled receiver and a gapped
    // sender; the budget covers that for every item, plus the table sweep after reset,
    // several times over.
    localparam int CYCLE_LIMIT  = 8000000;
    localparam int DRAIN_CYCLES = 64;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    localparam logic [7:0] SYM_OPEN  = 8'h28;
    localparam logic [7:0] SYM_CLOSE = 8'h29;
    localparam logic [7:0] SYM_MARK  = 8'h58;
    localparam logic [7:0] SYM_SIDE  = 8'h42;
    localparam logic [7:0] SYM_DEEP  = 8'h5b;
    localparam logic [7:0] SYM_LOOP  = 8'h7b;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } dir_row_t;

    localparam int NUM_DIRECTED = 26;

    // Directed part: a small bracket matcher, then a push loop that overflows
    // and a pop loop on the empty stack that runs into the step limit.
    dir_row_t directed_rows [NUM_DIRECTED] = '{
        {CMD_END,     4'd0,  8'h00,     4'd0,  ACT_READ,    1'b1, VERDICT_REJECTED, 1'b1},
        {CMD_SYMBOL,  4'd0,  8'h00,     4'd0,  ACT_READ,    1'b1, VERDICT_REJECTED, 1'b0},
        {CMD_UNKNOWN, 4'd15, 8'hff,     4'd15, ACT_UNKNOWN, 1'b1, VERDICT_REJECTED, 1'b0},
        {CMD_END,     4'd15, 8'hff,     4'd15, ACT_POP,     1'b1, VERDICT_REJECTED, 1'b1},
        {CMD_LOAD,    4'd0,  SYM_OPEN,  4'd1,  ACT_READ,    1'b1, VERDICT_PENDING,  1'b0},
        {CMD_LOAD,    4'd1,  SYM_MARK,  4'd0,  ACT_PUSH,    1'b0, VERDICT_PENDING,  1'b0},
        {CMD_LOAD,    4'd0,  SYM_CLOSE, 4'd2,  ACT_READ,    1'b0, VERDICT_PENDING,  1'b0},
        {CMD_LOAD,    4'd2,  SYM_MARK,  4'd0,  ACT_POP,     1'b0, VERDICT_PENDING,  1'b0},
        {CMD_LOAD,    4'd0,  END_BYTE,  4'd3,  ACT_READ,    1'b0, VERDICT_PENDING,  1'b0},
        {CMD_LOAD,    4'd3,  END_BYTE,  4'd15, ACT_POP,     1'b0, VERDICT_PENDING,  1'b0},
        {CMD_LOAD,    4'd0,  SYM_SIDE,  4'd15, ACT_UNKNOWN, 1'b0, VERDICT_PENDING,  1'b0},
        {CMD_SYMBOL,  4'd0,  SYM_OPEN,  4'd0,  ACT_READ,    1'b0, VERDICT_PENDING,  1'b0},
        {CMD_SYMBOL,  4'd0,  SYM_CLOSE, 4'd0,  ACT_READ,    1'b0, VERDICT_PENDING,  1'b0},
        {CMD_END,     4'd0,  8'h00,     4'd0,  ACT_READ,    1'b1, VERDICT_ACCEPTED, 1'b1},
        {CMD_SYMBOL,  4'd0,  SYM_SIDE,  4'd0,  ACT_READ,    1'b1, VERDICT_ACCEPTED, 1'b0},
        {CMD_SYMBOL,  4'd15, 8'hff,     4'd15, ACT_UNKNOWN, 1'b1, VERDICT_ACCEPTED, 1'b0},
        {CMD_END,     4'd0,  8'h00,     4'd0,  ACT_READ,    1'b1, VERDICT_ACCEPTED, 1'b1},
        {CMD_LOAD,    4'd0,  SYM_DEEP,  4'd5,  ACT_READ,    1'b0, VERDICT_PENDING,  1'b0},
        {CMD_LOAD,    4'd5,  SYM_MARK,  4'd5,  ACT_PUSH,    1'b0, VERDICT_PENDING,  1'b0},
        {CMD_SYMBOL,  4'd0,  SYM_DEEP,  4'd0,  ACT_READ,    1'b1, VERDICT_OVERFLOW, 1'b0},
        {CMD_END,     4'd0,  8'h00,     4'd0,  ACT_READ,    1'b1, VERDICT_OVERFLOW, 1'b1},
        {CMD_LOAD,    4'd0,  SYM_LOOP,  4'd6,  ACT_READ,    1'b0, VERDICT_PENDING,  1'b0},
        {CMD_LOAD,    4'd6,  END_BYTE,  4'd6,  ACT_POP,     1'b0, VERDICT_PENDING,  1'b0},
        {CMD_SYMBOL,  4'd0,  SYM_LOOP,  4'd0,  ACT_READ,    1'b1, VERDICT_STEPS,    1'b0},
        {CMD_END,     4'd0,  8'h00,     4'd0,  ACT_READ,    1'b1, VERDICT_STEPS,    1'b1},
        {CMD_LOAD,    4'd15, 8'hff,     4'd15, ACT_UNKNOWN, 1'b1, VERDICT_PENDING,  1'b0}
    };

    logic [7:0] alphabet [4] = '{8'h61, 8'h62, 8'h63, END_BYTE};

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_item_t   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [0:0] cfg_index = CFG_START;
    logic [3:0] cfg_data  = 4'd0;

    // Recognizer state as the testbench predicts it.
    bit          tr_valid [NUM_STATES * 256];
    logic [3:0]  tr_next  [NUM_STATES * 256];
    act_kind_t   st_act   [NUM_STATES];
    logic [7:0]  st_byte  [NUM_STATES];
    logic [7:0]  stack_mem [STACK_DEPTH];
    int unsigned stack_ptr;
    int unsigned step_count;
    logic [3:0]  cur_state;
    logic [2:0]  decided;
    bit          in_str;
    logic [3:0]  model_start;
    logic [3:0]  model_accept;

    out_item_t verdict_queue [$];
    out_item_t oldest;
    int        mismatch_count = 0;
    int        sent_count     = 0;
    int        cycle_count    = 0;
    int        src_idle_pct   = 16;
    int        rcv_stall_pct  = 52;

    pushdown_automaton_recognizer #(
        .NUM_STATES  (NUM_STATES),
        .STACK_DEPTH (STACK_DEPTH),
        .STEP_LIMIT  (STEP_LIMIT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_model();
        for (int i = 0; i < NUM_STATES * 256; i++)
        begin
            tr_valid[i] = 1'b0;
            tr_next[i]  = 4'd0;
        end
        for (int s = 0; s < NUM_STATES; s++)
        begin
            st_act[s]  = ACT_READ;
            st_byte[s] = 8'h00;
        end
        stack_ptr    = 0;
        step_count   = 0;
        cur_state    = 4'd0;
        decided      = VERDICT_PENDING;
        in_str       = 1'b0;
        model_start  = 4'd0;
        model_accept = 4'd15;
    endfunction

    function automatic void open_string();
        if (!in_str)
        begin
            in_str     = 1'b1;
            cur_state  = model_start;
            stack_ptr  = 0;
            step_count = 0;
            decided    = VERDICT_PENDING;
        end
    endfunction

    // Runs push, pop and read steps until a verdict, or until a read finds
    // no symbol left. At the end of the string every read sees END_BYTE.
    function automatic void run_steps(input bit ending, input logic [7:0] sym);
        bit         have;
        act_kind_t  kind;
        logic [7:0] c;
        int         key;
        have = !ending;
        while (1'b1)
        begin
            if (cur_state == model_accept)
            begin
                decided = VERDICT_ACCEPTED;
                return;
            end
            kind = st_act[cur_state];
            if (kind == ACT_READ && !ending && !have)
                return;
            if (step_count >= STEP_LIMIT)
            begin
                decided = VERDICT_STEPS;
                return;
            end
            step_count++;
            if (kind == ACT_PUSH)
            begin
                if (stack_ptr >= STACK_DEPTH)
                begin
                    decided = VERDICT_OVERFLOW;
                    return;
                end
                c = st_byte[cur_state];
                stack_mem[stack_ptr] = c;
                stack_ptr++;
            end
            else if (kind == ACT_POP)
            begin
                if (stack_ptr == 0)
                    c = END_BYTE;
                else
                begin
                    stack_ptr--;
                    c = stack_mem[stack_ptr];
                end
            end
            else if (ending)
                c = END_BYTE;
            else
            begin
                c = sym;
                have = 1'b0;
            end
            key = {cur_state, c};
            if (!tr_valid[key])
            begin
                decided = VERDICT_REJECTED;
                return;
            end
            cur_state = tr_next[key];
        end
    endfunction

    function automatic out_item_t recognize(input in_item_t it);
        out_item_t res;
        int        key;
        res.string_done = 1'b0;
        case (it.command)
            CMD_LOAD:
            begin
                key = {it.state_index, it.symbol};
                tr_valid[key] = 1'b1;
                tr_next[key]  = it.next_state;
                if (it.action_kind != ACT_UNKNOWN)
                begin
                    st_act[it.state_index]  = act_kind_t'(it.action_kind);
                    st_byte[it.state_index] = it.symbol;
                end
                res.verdict = decided;
            end
            CMD_SYMBOL:
            begin
                open_string();
                if (decided == VERDICT_PENDING)
                    run_steps(1'b0, it.symbol);
                res.verdict = decided;
            end
            CMD_END:
            begin
                open_string();
                if (decided == VERDICT_PENDING)
                    run_steps(1'b1, 8'h00);
                res.verdict     = decided;
                res.string_done = 1'b1;
                in_str     = 1'b0;
                stack_ptr  = 0;
                step_count = 0;
                decided    = VERDICT_PENDING;
                cur_state  = model_start;
            end
            default:
            begin
                res.verdict = decided;
            end
        endcase
        return res;
    endfunction

    function automatic in_item_t make_item(input logic [1:0] cmd, input logic [3:0] st,
                                           input logic [7:0] sym, input logic [3:0] nx,
                                           input logic [1:0] act);
        in_item_t it;
        it.command     = cmd;
        it.state_index = st;
        it.symbol      = sym;
        it.next_state  = nx;
        it.action_kind = act;
        return it;
    endfunction

    // Symbol and end transactions carry random values in the fields they ignore.
    function automatic in_item_t text_item(input logic [1:0] cmd, input logic [7:0] sym);
        return make_item(cmd, 4'($urandom_range(0, 15)), sym, 4'($urandom_range(0, 15)),
                         2'($urandom_range(0, 3)));
    endfunction

    function automatic logic [3:0] pick_next();
        if ($urandom_range(0, 99) < 20)
            return model_accept;
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                             input out_item_t want = '0);
        out_item_t got;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        got = recognize(it);
        verdict_queue.push_back(typed ? want : got);
        sent_count++;
    endtask

    // Always waits on a clock edge before checking the queue, so in_valid never gets two updates in one step.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (verdict_queue.size() != 0);
    endtask

    task automatic set_config(input logic [3:0] start, input logic [3:0] accept);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_START;
        cfg_data  <= start;
        do
            @(posedge clk);
        while (!cfg_ready);
        model_start = start;
        cfg_index <= CFG_ACCEPT;
        cfg_data  <= accept;
        do
            @(posedge clk);
        while (!cfg_ready);
        model_accept = accept;
        cfg_valid <= 1'b0;
    endtask

    // Reprograms about half of the states with a random action and a few
    // transitions over a small alphabet, so that strings run deep.
    task automatic load_program();
        int r;
        for (int s = 0; s < NUM_STATES; s++)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    for (int b = 0; b < 4; b++)
                        if ($urandom_range(0, 9) < 7)
                            send_item(make_item(CMD_LOAD, 4'(s), alphabet[b], pick_next(),
                                                ACT_READ));
                end
                else if (r < 75)
                    send_item(make_item(CMD_LOAD, 4'(s), alphabet[$urandom_range(0, 3)],
                                        pick_next(), ACT_PUSH));
                else if (r < 95)
                begin
                    for (int b = 0; b < 4; b++)
                        if ($urandom_range(0, 3) != 0)
                            send_item(make_item(CMD_LOAD, 4'(s), alphabet[b], pick_next(),
                                                ACT_POP));
                end
                else
                    send_item(make_item(CMD_LOAD, 4'(s), 8'($urandom_range(0, 255)),
                                        pick_next(), ACT_UNKNOWN));
            end
        end
    endtask

    task automatic run_session();
        int       len;
        in_item_t it;
        if ($urandom_range(0, 19) == 0)
            hold_until_drained();
        if ($urandom_range(0, 99) < 35)
            load_program();
        repeat ($urandom_range(1, 4))
        begin
            len = $urandom_range(0, 10);
            repeat (len)
            begin
                if ($urandom_range(0, 99) < 8)
                    it = 20'($urandom_range(0, 20'hfffff));
                else if ($urandom_range(0, 9) == 0)
                    it = text_item(CMD_SYMBOL, 8'($urandom_range(0, 255)));
                else
                    it = text_item(CMD_SYMBOL, alphabet[$urandom_range(0, 3)]);
                send_item(it);
            end
            // Now and then a string runs on into the next one without an end.
            if ($urandom_range(0, 19) != 0)
                send_item(text_item(CMD_END, 8'($urandom_range(0, 255))));
        end
    endtask

    task automatic run_phase(input logic [3:0] start, input logic [3:0] accept,
                             input int src_pct, input int rcv_pct, input int target);
        hold_until_drained();
        set_config(start, accept);
        src_idle_pct  = src_pct;
        rcv_stall_pct = rcv_pct;
        load_program();
        while (sent_count < target)
            run_session();
    endtask

    // Result side: random stalls, and each transaction checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_queue.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual verdict %0d done %0d",
                         $time, out_data.verdict, out_data.string_done);
                mismatch_count++;
            end
            else
            begin
                oldest = verdict_queue.pop_front();
                if (out_data.verdict !== oldest.verdict)
                begin
                    $display("%0t: verdict mismatch, expected %0d, actual %0d",
                             $time, oldest.verdict, out_data.verdict);
                    mismatch_count++;
                end
                if (out_data.string_done !== oldest.string_done)
                begin
                    $display("%0t: string_done mismatch, expected %0d, actual %0d",
                             $time, oldest.string_done, out_data.string_done);
                    mismatch_count++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        clear_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        // Start equal to accept first, then both extreme orders, then a random setting.
        run_phase(4'd15, 4'd15, 16, 52, 60);
        run_phase(4'd0, 4'd15, 16, 52, 640);
        run_phase(4'd15, 4'd0, 52, 16, 1200);
        run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 0, 0, 1750);

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
